[rtl/ncp_pkg.sv]
`default_nettype none
package ncp_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = 25;
    localparam int NUM_W   = 51;
    localparam int DEN_W   = 50;
    localparam int REM_W   = 52;
    localparam int QUO_W   = 25;

    localparam logic [1:0] OP_WR_POINT   = 2'd0;
    localparam logic [1:0] OP_WR_SEGMENT = 2'd1;
    localparam logic [1:0] OP_QUERY      = 2'd2;

    localparam logic [1:0] CFG_POINT_COUNT   = 2'd0;
    localparam logic [1:0] CFG_SEGMENT_COUNT = 2'd1;
    localparam logic [1:0] CFG_DEGEN_EPS     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PT_ISSUE,
        ST_PT_DATA,
        ST_SEG_ISSUE,
        ST_SEG_DATA,
        ST_SEG_WAIT,
        ST_ABS,
        ST_SQX,
        ST_SQY,
        ST_CMP,
        ST_FINISH
    } ncp_state_t;

    typedef enum logic [2:0] {
        SG_IDLE,
        SG_PREP,
        SG_MUL,
        SG_CMP,
        SG_DIV,
        SG_DONE
    } seg_state_t;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] sax;
        logic [COORD_W-1:0] say;
        logic [COORD_W-1:0] sbx;
        logic [COORD_W-1:0] sby;
        logic [COORD_W-1:0] qx;
        logic [COORD_W-1:0] qy;
        logic [7:0]         eps;
    } seg_req_t;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } seg_res_t;

    typedef struct packed {
        logic [REM_W-1:0] r;
        logic [QUO_W-1:0] q;
    } div_t;

    // One bit of floor(num * mag / den), most significant magnitude bit first.
    function automatic div_t div_step(div_t cur, logic [DEN_W-1:0] num,
                                      logic [DEN_W-1:0] den, logic mag_bit);
        div_t             nxt;
        logic [REM_W-1:0] den_ext;
        den_ext = {2'b00, den};
        nxt.r = {cur.r[REM_W-2:0], 1'b0};
        nxt.q = {cur.q[QUO_W-2:0], 1'b0};
        if (nxt.r >= den_ext)
        begin
            nxt.r = nxt.r - den_ext;
            nxt.q = nxt.q + QUO_W'(1);
        end
        if (mag_bit)
        begin
            nxt.r = nxt.r + {2'b00, num};
            if (nxt.r >= den_ext)
            begin
                nxt.r = nxt.r - den_ext;
                nxt.q = nxt.q + QUO_W'(1);
            end
        end
        return nxt;
    endfunction

endpackage
`default_nettype wire

[rtl/ncp_store.sv]
`default_nettype none
module ncp_store #(
    parameter int MAX_POINTS   = 256,
    parameter int MAX_SEGMENTS = 256,
    parameter int PAW          = 8,
    parameter int SAW          = 8
) (
    input  wire logic            clk,
    input  wire logic            pt_we,
    input  wire logic [PAW-1:0]  pt_waddr,
    input  wire logic [47:0]     pt_wdata,
    input  wire logic [PAW-1:0]  pt_raddr,
    output logic      [47:0]     pt_rdata,
    input  wire logic            seg_we,
    input  wire logic [SAW-1:0]  seg_waddr,
    input  wire logic [95:0]     seg_wdata,
    input  wire logic [SAW-1:0]  seg_raddr,
    output logic      [95:0]     seg_rdata
);
    logic [47:0] pt_mem  [MAX_POINTS];
    logic [95:0] seg_mem [MAX_SEGMENTS];

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        pt_rdata <= pt_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (seg_we)
        begin
            seg_mem[seg_waddr] <= seg_wdata;
        end
        seg_rdata <= seg_mem[seg_raddr];
    end

endmodule
`default_nettype wire

[rtl/ncp_seg.sv]
`default_nettype none
module ncp_seg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ncp_pkg::seg_req_t req,
    output ncp_pkg::seg_res_t      res
);
    import ncp_pkg::*;

    seg_state_t state_reg, state_next;

    logic [COORD_W-1:0]       sax_reg, say_reg, sbx_reg, sby_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, ux_reg, uy_reg;
    logic [7:0]               eps_reg;
    logic [2:0]               mul_k_reg;
    logic signed [2*DIFF_W-1:0] prod_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [4:0]               bit_reg;
    div_t                     divx_reg, divy_reg;
    logic [COORD_W-1:0]       cx_reg, cy_reg;

    logic signed [DIFF_W-1:0] mul_a, mul_b;
    logic [DIFF_W-1:0]        adx, ady;
    logic                     degen;
    div_t                     divx_nxt, divy_nxt;
    logic [DIFF_W-1:0]        offx_sum, offy_sum;

    assign adx   = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
    assign ady   = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
    assign degen = (adx <= {17'd0, eps_reg}) && (ady <= {17'd0, eps_reg});

    always_comb
    begin
        case (mul_k_reg)
            3'd0:
            begin
                mul_a = ux_reg;
                mul_b = dx_reg;
            end
            3'd1:
            begin
                mul_a = uy_reg;
                mul_b = dy_reg;
            end
            3'd2:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            3'd3:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign divx_nxt = div_step(divx_reg, num_reg[DEN_W-1:0], den_reg, adx[bit_reg]);
    assign divy_nxt = div_step(divy_reg, num_reg[DEN_W-1:0], den_reg, ady[bit_reg]);
    assign offx_sum = dx_reg[DIFF_W-1] ? ({1'b0, sax_reg} - divx_nxt.q)
                                       : ({1'b0, sax_reg} + divx_nxt.q);
    assign offy_sum = dy_reg[DIFF_W-1] ? ({1'b0, say_reg} - divy_nxt.q)
                                       : ({1'b0, say_reg} + divy_nxt.q);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SG_IDLE:
            begin
                if (req.start)
                begin
                    state_next = SG_PREP;
                end
            end
            SG_PREP:
            begin
                state_next = degen ? SG_DONE : SG_MUL;
            end
            SG_MUL:
            begin
                if (mul_k_reg == 3'd4)
                begin
                    state_next = SG_CMP;
                end
            end
            SG_CMP:
            begin
                if (num_reg[NUM_W-1] || (num_reg[DEN_W-1:0] > den_reg))
                begin
                    state_next = SG_DONE;
                end
                else
                begin
                    state_next = SG_DIV;
                end
            end
            SG_DIV:
            begin
                if (bit_reg == 5'd0)
                begin
                    state_next = SG_DONE;
                end
            end
            SG_DONE:
            begin
                state_next = SG_IDLE;
            end
            default:
            begin
                state_next = SG_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.done = (state_reg == SG_DONE);
        res.cx   = cx_reg;
        res.cy   = cy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SG_IDLE;
            mul_k_reg <= 3'd0;
            bit_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SG_IDLE)
            begin
                mul_k_reg <= 3'd0;
                bit_reg   <= 5'd24;
            end
            else if (state_reg == SG_MUL)
            begin
                mul_k_reg <= mul_k_reg + 3'd1;
            end
            else if (state_reg == SG_DIV)
            begin
                bit_reg <= bit_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SG_IDLE:
            begin
                sax_reg <= req.sax;
                say_reg <= req.say;
                sbx_reg <= req.sbx;
                sby_reg <= req.sby;
                eps_reg <= req.eps;
                dx_reg  <= $signed({1'b0, req.sbx}) - $signed({1'b0, req.sax});
                dy_reg  <= $signed({1'b0, req.sby}) - $signed({1'b0, req.say});
                ux_reg  <= $signed({1'b0, req.qx}) - $signed({1'b0, req.sax});
                uy_reg  <= $signed({1'b0, req.qy}) - $signed({1'b0, req.say});
                num_reg <= '0;
                den_reg <= '0;
            end
            SG_PREP:
            begin
                cx_reg <= sax_reg;
                cy_reg <= say_reg;
            end
            SG_MUL:
            begin
                prod_reg <= mul_a * mul_b;
                if ((mul_k_reg == 3'd1) || (mul_k_reg == 3'd2))
                begin
                    num_reg <= num_reg + {prod_reg[2*DIFF_W-1], prod_reg};
                end
                else if ((mul_k_reg == 3'd3) || (mul_k_reg == 3'd4))
                begin
                    den_reg <= den_reg + prod_reg[DEN_W-1:0];
                end
            end
            SG_CMP:
            begin
                divx_reg <= '0;
                divy_reg <= '0;
                if (num_reg[NUM_W-1])
                begin
                    cx_reg <= sax_reg;
                    cy_reg <= say_reg;
                end
                else
                begin
                    cx_reg <= sbx_reg;
                    cy_reg <= sby_reg;
                end
            end
            SG_DIV:
            begin
                divx_reg <= divx_nxt;
                divy_reg <= divy_nxt;
                if (bit_reg == 5'd0)
                begin
                    cx_reg <= offx_sum[COORD_W-1:0];
                    cy_reg <= offy_sum[COORD_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/nearest_connection_point.sv]
`default_nettype none
// Channel        Direction  Handshake            Payload
// input items    in         in_valid / in_stall  op, slot, ax, ay, bx, by_coord
// results        out        out_valid / out_stall found, near_x, near_y
// configuration  in         cfg_we               cfg_index, cfg_wdata
//
// A write transaction is taken without leaving the idle state; a query walks each point
// in use, then each segment in use, which may run the 25-step bit-serial projection divider.
// Each entry in use is read from a synchronous memory in turn.
// Reset clears control state and configuration; the tables are undefined until written.
// The result sits in an output register, so writes are accepted while it waits.
module nearest_connection_point #(
    parameter int MAX_POINTS   = 256,
    parameter int MAX_SEGMENTS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  slot,
    input  wire logic [23:0] ax,
    input  wire logic [23:0] ay,
    input  wire logic [23:0] bx,
    input  wire logic [23:0] by_coord,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             found,
    output logic [23:0]      near_x,
    output logic [23:0]      near_y
);
    import ncp_pkg::*;

    localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int SCW = $clog2(MAX_SEGMENTS + 1);
    localparam int IW0 = (PCW > SCW) ? PCW : SCW;
    localparam int XW  = (IW0 > 9) ? IW0 : 9;

    ncp_state_t state_reg, state_next;

    logic [8:0]         pc_reg, sc_reg;
    logic [7:0]         eps_reg;
    logic [XW-1:0]      idx_reg;
    logic               seg_phase_reg;
    logic [COORD_W-1:0] qx_reg, qy_reg, cand_x_reg, cand_y_reg;
    logic [COORD_W-1:0] adx_reg, ady_reg;
    logic [47:0]        sqx_reg, sqy_reg;
    logic [48:0]        best_reg;
    logic               have_reg;
    logic [COORD_W-1:0] best_x_reg, best_y_reg;
    logic               out_valid_reg, found_reg;
    logic [COORD_W-1:0] near_x_reg, near_y_reg;

    logic [XW-1:0]      np, ns;
    logic               accept;
    logic               pt_we, seg_we;
    logic [47:0]        pt_rdata;
    logic [95:0]        seg_rdata;
    logic [48:0]        sq_sum;
    logic               better;
    logic               out_free;
    seg_req_t           seg_req;
    seg_res_t           seg_res;

    assign np = (XW'(pc_reg) > XW'(MAX_POINTS)) ? XW'(MAX_POINTS) : XW'(pc_reg);
    assign ns = (XW'(sc_reg) > XW'(MAX_SEGMENTS)) ? XW'(MAX_SEGMENTS) : XW'(sc_reg);

    assign accept = in_valid && !in_stall;
    assign pt_we  = accept && (op == OP_WR_POINT) && (32'(slot) < 32'(MAX_POINTS));
    assign seg_we = accept && (op == OP_WR_SEGMENT) && (32'(slot) < 32'(MAX_SEGMENTS));

    assign sq_sum   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign better   = !have_reg || (sq_sum < best_reg);
    assign out_free = !out_valid_reg || !out_stall;

    ncp_store #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .PAW          (PAW),
        .SAW          (SAW)
    ) u_store (
        .clk       (clk),
        .pt_we     (pt_we),
        .pt_waddr  (PAW'(slot)),
        .pt_wdata  ({ax, ay}),
        .pt_raddr  (idx_reg[PAW-1:0]),
        .pt_rdata  (pt_rdata),
        .seg_we    (seg_we),
        .seg_waddr (SAW'(slot)),
        .seg_wdata ({ax, ay, bx, by_coord}),
        .seg_raddr (idx_reg[SAW-1:0]),
        .seg_rdata (seg_rdata)
    );

    always_comb
    begin
        seg_req.start = (state_reg == ST_SEG_DATA);
        seg_req.sax   = seg_rdata[95:72];
        seg_req.say   = seg_rdata[71:48];
        seg_req.sbx   = seg_rdata[47:24];
        seg_req.sby   = seg_rdata[23:0];
        seg_req.qx    = qx_reg;
        seg_req.qy    = qy_reg;
        seg_req.eps   = eps_reg;
    end

    ncp_seg u_seg (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (seg_req),
        .res   (seg_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_QUERY))
                begin
                    state_next = ST_PT_ISSUE;
                end
            end
            ST_PT_ISSUE:
            begin
                state_next = (idx_reg < np) ? ST_PT_DATA : ST_SEG_ISSUE;
            end
            ST_PT_DATA:
            begin
                state_next = ST_ABS;
            end
            ST_SEG_ISSUE:
            begin
                state_next = (idx_reg < ns) ? ST_SEG_DATA : ST_FINISH;
            end
            ST_SEG_DATA:
            begin
                state_next = ST_SEG_WAIT;
            end
            ST_SEG_WAIT:
            begin
                if (seg_res.done)
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:
            begin
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = seg_phase_reg ? ST_SEG_ISSUE : ST_PT_ISSUE;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = out_valid_reg;
        found     = found_reg;
        near_x    = near_x_reg;
        near_y    = near_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            sc_reg        <= '0;
            eps_reg       <= '0;
            idx_reg       <= '0;
            seg_phase_reg <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POINT_COUNT:   pc_reg  <= cfg_wdata;
                    CFG_SEGMENT_COUNT: sc_reg  <= cfg_wdata;
                    CFG_DEGEN_EPS:     eps_reg <= cfg_wdata[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if ((state_reg == ST_IDLE) && accept && (op == OP_QUERY))
            begin
                idx_reg       <= '0;
                seg_phase_reg <= 1'b0;
                have_reg      <= 1'b0;
            end
            else if ((state_reg == ST_PT_ISSUE) && !(idx_reg < np))
            begin
                idx_reg       <= '0;
                seg_phase_reg <= 1'b1;
            end
            else if (state_reg == ST_CMP)
            begin
                idx_reg <= idx_reg + XW'(1);
                if (better)
                begin
                    have_reg <= 1'b1;
                end
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && accept && (op == OP_QUERY))
        begin
            qx_reg     <= ax;
            qy_reg     <= ay;
            best_x_reg <= '0;
            best_y_reg <= '0;
        end
        if (state_reg == ST_PT_DATA)
        begin
            cand_x_reg <= pt_rdata[47:24];
            cand_y_reg <= pt_rdata[23:0];
        end
        if ((state_reg == ST_SEG_WAIT) && seg_res.done)
        begin
            cand_x_reg <= seg_res.cx;
            cand_y_reg <= seg_res.cy;
        end
        if (state_reg == ST_ABS)
        begin
            adx_reg <= (qx_reg > cand_x_reg) ? (qx_reg - cand_x_reg) : (cand_x_reg - qx_reg);
            ady_reg <= (qy_reg > cand_y_reg) ? (qy_reg - cand_y_reg) : (cand_y_reg - qy_reg);
        end
        if (state_reg == ST_SQX)
        begin
            sqx_reg <= adx_reg * adx_reg;
        end
        if (state_reg == ST_SQY)
        begin
            sqy_reg <= ady_reg * ady_reg;
        end
        if ((state_reg == ST_CMP) && better)
        begin
            best_reg   <= sq_sum;
            best_x_reg <= cand_x_reg;
            best_y_reg <= cand_y_reg;
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            found_reg  <= have_reg;
            near_x_reg <= best_x_reg;
            near_y_reg <= best_y_reg;
        end
    end

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> ((near_x == '0) && (near_y == '0)))
        else $error("empty search returned a non-zero point");

    a_seg_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        seg_res.done |-> (state_reg == ST_SEG_WAIT))
        else $error("segment unit finished outside its wait state");

    a_pt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PT_DATA) |-> (idx_reg < np))
        else $error("point read beyond the count in use");

    a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEG_DATA) |-> (seg_phase_reg && (idx_reg < ns)))
        else $error("segment read beyond the count in use");

    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && out_free) |=> (out_valid && (state_reg == ST_IDLE)))
        else $error("finished query did not present a result");

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
    import ncp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD = 400;
    localparam int NUM_FIXED = 10;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  slot;
        logic [23:0] ax;
        logic [23:0] ay;
        logic [23:0] bx;
        logic [23:0] by;
    } request_t;

    typedef struct packed {
        logic        found;
        logic [23:0] x;
        logic [23:0] y;
    } nearest_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        nearest_t want;
    } vector_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [7:0]  slot;
    logic [23:0] ax;
    logic [23:0] ay;
    logic [23:0] bx;
    logic [23:0] by_coord;
    logic        out_valid;
    logic        out_stall;
    logic        found;
    logic [23:0] near_x;
    logic [23:0] near_y;

    logic [23:0] pt_x [256];
    logic [23:0] pt_y [256];
    logic [23:0] sa_x [256];
    logic [23:0] sa_y [256];
    logic [23:0] sb_x [256];
    logic [23:0] sb_y [256];
    logic [8:0]  used_points;
    logic [8:0]  used_segments;
    logic [7:0]  eps;

    nearest_t    pending_nearest [$];
    int          errors;
    int          queries;
    int          point_writes;
    int          segment_writes;
    int          phases;
    int          idle_cycles;
    bit          quiet;
    bit          hold_req;
    logic [23:0] ctr_x;
    logic [23:0] ctr_y;

    nearest_connection_point DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .slot      (slot),
        .ax        (ax),
        .ay        (ay),
        .bx        (bx),
        .by_coord  (by_coord),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .near_x    (near_x),
        .near_y    (near_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] dist2(logic [23:0] x0, logic [23:0] y0,
                                          logic [23:0] x1, logic [23:0] y1);
        logic [63:0] dx;
        logic [63:0] dy;
        dx = (x0 > x1) ? 64'(x0 - x1) : 64'(x1 - x0);
        dy = (y0 > y1) ? 64'(y0 - y1) : 64'(y1 - y0);
        return dx * dx + dy * dy;
    endfunction

    function automatic logic [23:0] along_axis(logic [23:0] s, longint d, longint num,
                                               longint den);
        logic [127:0] mag;
        logic [127:0] off;
        mag = (d < 0) ? 128'(-d) : 128'(d);
        off = (128'(num) * mag) / 128'(den);
        return (d < 0) ? 24'(128'(s) - off) : 24'(128'(s) + off);
    endfunction

    function automatic nearest_t nearest_to(logic [23:0] qx, logic [23:0] qy);
        nearest_t    r;
        logic [63:0] best;
        logic [63:0] d;
        logic [23:0] cx;
        logic [23:0] cy;
        longint      dx;
        longint      dy;
        longint      num;
        longint      den;
        longint      e;
        int          np;
        int          ns;
        r = '0;
        best = '0;
        e = longint'(eps);
        np = (used_points > 256) ? 256 : int'(used_points);
        ns = (used_segments > 256) ? 256 : int'(used_segments);
        for (int i = 0; i < np; i++)
        begin
            d = dist2(qx, qy, pt_x[i], pt_y[i]);
            if (!r.found || d < best)
            begin
                r = '{1'b1, pt_x[i], pt_y[i]};
                best = d;
            end
        end
        for (int i = 0; i < ns; i++)
        begin
            dx = longint'(sb_x[i]) - longint'(sa_x[i]);
            dy = longint'(sb_y[i]) - longint'(sa_y[i]);
            num = (longint'(qx) - longint'(sa_x[i])) * dx
                + (longint'(qy) - longint'(sa_y[i])) * dy;
            den = dx * dx + dy * dy;
            if ((dx <= e && -dx <= e && dy <= e && -dy <= e) || num < 0)
            begin
                cx = sa_x[i];
                cy = sa_y[i];
            end
            else if (num > den)
            begin
                cx = sb_x[i];
                cy = sb_y[i];
            end
            else
            begin
                cx = along_axis(sa_x[i], dx, num, den);
                cy = along_axis(sa_y[i], dy, num, den);
            end
            d = dist2(qx, qy, cx, cy);
            if (!r.found || d < best)
            begin
                r = '{1'b1, cx, cy};
                best = d;
            end
        end
        return r;
    endfunction

    task automatic absorb(vector_t v);
        case (v.req.op)
            OP_WR_POINT:
            begin
                pt_x[v.req.slot] = v.req.ax;
                pt_y[v.req.slot] = v.req.ay;
                point_writes++;
            end
            OP_WR_SEGMENT:
            begin
                sa_x[v.req.slot] = v.req.ax;
                sa_y[v.req.slot] = v.req.ay;
                sb_x[v.req.slot] = v.req.bx;
                sb_y[v.req.slot] = v.req.by;
                segment_writes++;
            end
            OP_QUERY:
            begin
                pending_nearest.push_back(v.typed ? v.want : nearest_to(v.req.ax, v.req.ay));
                queries++;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send(vector_t v);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= v.req.op;
        slot <= v.req.slot;
        ax <= v.req.ax;
        ay <= v.req.ay;
        bx <= v.req.bx;
        by_coord <= v.req.by;
        do @(posedge clk); while (in_stall);
        absorb(v);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_nearest.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [8:0] p, logic [8:0] s, logic [8:0] e);
        cfg_we <= 1'b1;
        cfg_index <= CFG_POINT_COUNT;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_index <= CFG_SEGMENT_COUNT;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_index <= CFG_DEGEN_EPS;
        cfg_wdata <= e;
        @(posedge clk);
        cfg_we <= 1'b0;
        used_points = p;
        used_segments = s;
        eps = e[7:0];
        phases++;
    endtask

    function automatic logic [23:0] any_coord();
        return 24'($urandom);
    endfunction

    function automatic logic [23:0] pick(logic [23:0] c);
        return ($urandom_range(0, 3) == 0) ? any_coord() : c + 24'($urandom_range(0, 4095));
    endfunction

    function automatic logic [23:0] nudge(logic [23:0] c);
        logic [23:0] off;
        off = 24'($urandom_range(0, int'(eps) + 2));
        return (c > 24'hFFFF00) ? c - off : c + off;
    endfunction

    function automatic vector_t random_vector();
        vector_t v;
        int      k;
        int      lim;
        v = '0;
        k = $urandom_range(0, 99);
        lim = (used_points > used_segments) ? int'(used_points) : int'(used_segments);
        lim = (lim > 256) ? 256 : ((lim < 1) ? 1 : lim);
        v.req.slot = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, lim - 1));
        v.req.ax = pick(ctr_x);
        v.req.ay = pick(ctr_y);
        v.req.bx = any_coord();
        v.req.by = any_coord();
        if (k < 8)
            v.req.op = OP_UNUSED;
        else if (k < 35)
            v.req.op = OP_WR_POINT;
        else if (k < 60)
        begin
            v.req.op = OP_WR_SEGMENT;
            if ($urandom_range(0, 2) == 0)
            begin
                v.req.bx = nudge(v.req.ax);
                v.req.by = nudge(v.req.ay);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                v.req.bx = pick(ctr_x);
                v.req.by = pick(ctr_y);
            end
        end
        else
            v.req.op = OP_QUERY;
        return v;
    endfunction

    task automatic report(string what, nearest_t want, nearest_t got);
        errors++;
        if (errors <= 10)
            $display("MISMATCH %s: expected found=%0d x=%06h y=%06h, got found=%0d x=%06h y=%06h",
                     what, want.found, want.x, want.y, got.found, got.x, got.y);
    endtask

    initial
    begin
        nearest_t got;
        nearest_t want;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = '{found, near_x, near_y};
                if (pending_nearest.size() == 0)
                    report("unexpected result", '0, got);
                else
                begin
                    want = pending_nearest.pop_front();
                    if (got.found !== want.found || got.x !== want.x || got.y !== want.y)
                        report("result", want, got);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog expired with %0d results outstanding", pending_nearest.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int hold_left;
        int burst_left;
        hold_left = 0;
        burst_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                burst_left = $urandom_range(0, 18);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        vector_t directed [] = '{
            '{'{OP_WR_POINT, 8'd0, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b0, '0},
            '{'{OP_WR_SEGMENT, 8'd0, 24'd1000, 24'd0, 24'd2000, 24'd0}, 1'b0, '0},
            '{'{OP_QUERY, 8'd0, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b1, '{1'b1, 24'd0, 24'd0}},
            '{'{OP_QUERY, 8'd0, 24'd1500, 24'd50, 24'd0, 24'd0}, 1'b1,
              '{1'b1, 24'd1500, 24'd0}},
            '{'{OP_QUERY, 8'd0, 24'd3000, 24'd0, 24'd0, 24'd0}, 1'b1,
              '{1'b1, 24'd2000, 24'd0}},
            '{'{OP_QUERY, 8'd0, 24'd900, 24'd0, 24'd0, 24'd0}, 1'b1,
              '{1'b1, 24'd1000, 24'd0}},
            '{'{OP_WR_POINT, 8'd0, 24'd1000, 24'd0, 24'd0, 24'd0}, 1'b0, '0},
            '{'{OP_QUERY, 8'd0, 24'd1000, 24'd5, 24'd0, 24'd0}, 1'b1,
              '{1'b1, 24'd1000, 24'd0}},
            '{'{OP_WR_POINT, 8'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0}, 1'b0, '0},
            '{'{OP_QUERY, 8'd0, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b1, '{1'b1, 24'd1000, 24'd0}},
            '{'{OP_QUERY, 8'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0}, 1'b1,
              '{1'b1, 24'hFFFFFF, 24'hFFFFFF}},
            '{'{OP_WR_SEGMENT, 8'd0, 24'd500, 24'd500, 24'd500, 24'd500}, 1'b0, '0},
            '{'{OP_QUERY, 8'd0, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b1, '{1'b1, 24'd500, 24'd500}},
            '{'{OP_WR_SEGMENT, 8'd0, 24'd0, 24'd0, 24'd3, 24'd3}, 1'b0, '0},
            '{'{OP_QUERY, 8'd0, 24'd1, 24'd0, 24'd0, 24'd0}, 1'b0, '0},
            '{'{OP_WR_SEGMENT, 8'd0, 24'd2000, 24'd2000, 24'd1000, 24'd1000}, 1'b0, '0},
            '{'{OP_QUERY, 8'd0, 24'd1500, 24'd1400, 24'd0, 24'd0}, 1'b0, '0},
            '{'{OP_WR_SEGMENT, 8'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, '0},
            '{'{OP_QUERY, 8'd0, 24'hFFFFFF, 24'd0, 24'd0, 24'd0}, 1'b0, '0},
            '{'{OP_UNUSED, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, '0}
        };
        int      fix_p [NUM_FIXED] = '{3, 8, 1, 0, 16, 2, 511, 256, 5, 0};
        int      fix_s [NUM_FIXED] = '{2, 8, 0, 1, 4, 12, 300, 256, 5, 0};
        int      fix_e [NUM_FIXED] = '{0, 5, 0, 255, 40, 0, 511, 0, 20, 0};
        int      fix_n [NUM_FIXED] = '{60, 60, 40, 40, 60, 60, 6, 6, 60, 10};
        int      counted;
        int      n;
        int      ph;
        bit      last;
        vector_t v;

        errors = 0;
        queries = 0;
        point_writes = 0;
        segment_writes = 0;
        phases = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        used_points = '0;
        used_segments = '0;
        eps = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        op = '0;
        slot = '0;
        ax = '0;
        ay = '0;
        bx = '0;
        by_coord = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With both tables empty the search must report nothing found.
        send('{'{OP_QUERY, 8'd0, 24'h123456, 24'h654321, 24'd0, 24'd0}, 1'b1, '0});
        for (int i = 0; i < 256; i++)
        begin
            send('{'{OP_WR_POINT, 8'(i), any_coord(), any_coord(), 24'd0, 24'd0}, 1'b0, '0});
            send('{'{OP_WR_SEGMENT, 8'(i), any_coord(), any_coord(), any_coord(), any_coord()},
                   1'b0, '0});
        end
        settle();
        configure(9'd1, 9'd1, 9'd0);
        foreach (directed[i])
            send(directed[i]);

        counted = 0;
        ph = 0;
        last = 1'b0;
        while (!last)
        begin
            settle();
            if (ph < NUM_FIXED)
            begin
                configure(9'(fix_p[ph]), 9'(fix_s[ph]), 9'(fix_e[ph]));
                n = fix_n[ph];
                quiet = 1'b0;
            end
            else
            begin
                last = (counted >= 400);
                configure(9'($urandom_range(0, 12)), 9'($urandom_range(0, 12)),
                          ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 30)));
                n = last ? 80 : 60;
                quiet = last || ($urandom_range(0, 3) == 0);
            end
            ctr_x = 24'($urandom_range(0, 24'hFFFFFF - 4096));
            ctr_y = 24'($urandom_range(0, 24'hFFFFFF - 4096));
            if (ph == 2)
                hold_req = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                if (ph == 1 && i == n / 2)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending_nearest.size() != 0) @(posedge clk);
                end
                v = random_vector();
                send(v);
                if (v.req.op != OP_UNUSED)
                    counted++;
            end
            ph++;
        end
        settle();

        $display("Run covered %0d queries, %0d point and %0d segment writes", queries,
                 point_writes, segment_writes);
        $display("across %0d register settings, with %0d mismatches.", phases, errors);
        if (errors == 0 && pending_nearest.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/ncp_pkg.sv
rtl/ncp_store.sv
rtl/ncp_seg.sv
rtl/nearest_connection_point.sv
verif/tb.sv
